@@ sv/tofh_pkg.sv @@
package tofh_pkg;

	// histogram geometry
	localparam int NUM_STEPS    = 64;
	localparam int TOF_CHANNELS = 1024;
	localparam int DEPTH        = NUM_STEPS * TOF_CHANNELS;
	localparam int ADDR_W       = $clog2(DEPTH);

	// field widths
	localparam int OP_W     = 2;
	localparam int STEP_W   = 6;
	localparam int CH_W     = 10;
	localparam int WEIGHT_W = 16;
	localparam int BIN_W    = 32;
	localparam int VALUE_W  = 42;
	localparam int COUNT_W  = 32;

	// comparison widths for range checks
	localparam int NB_W      = $clog2(TOF_CHANNELS + 1);
	localparam int CMP_W     = (NB_W > CH_W) ? NB_W : CH_W;
	localparam int STEPC_RAW = $clog2(NUM_STEPS + 1);
	localparam int STEPC_W   = (STEPC_RAW > STEP_W) ? STEPC_RAW : STEP_W;

	// configuration
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 3;
	localparam int SHIFT_W     = 3;
	localparam int MAX_SHIFT   = 4;
	localparam int ONE_COUNT   = 256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_USE_WEIGHT  = 1'b0,
		REG_RESOL_SHIFT = 1'b1
	} cfg_reg_t;

	typedef enum logic [OP_W-1:0] {
		OP_ACCUM = 2'd0,
		OP_READ  = 2'd1,
		OP_SUM   = 2'd2
	} opcode_t;

	typedef struct packed {
		logic [OP_W-1:0]     opcode;
		logic [STEP_W-1:0]   step_index;
		logic [CH_W-1:0]     tof_channel;
		logic [CH_W-1:0]     stop_channel;
		logic [WEIGHT_W-1:0] weight;
		logic                filter_pass;
	} in_item_t;

	typedef struct packed {
		logic               accepted;
		logic [VALUE_W-1:0] value;
		logic               error;
		logic [COUNT_W-1:0] used_count;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic latch;
		logic clr_wr;
		logic sum_step;
		logic fire;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic walk;
		logic sum_last;
		logic out_free;
	} sts_t;

endpackage

@@ sv/tofh_ram.sv @@
module tofh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/tofh_ctrl.sv @@
module tofh_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  tofh_pkg::sts_t sts,
	output tofh_pkg::cmd_t cmd
);
	import tofh_pkg::*;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   in_stall_q;

	assign in_stall = in_stall_q;

	always_comb begin
		cmd          = '0;
		cmd.latch    = (state_q == ST_IDLE) && in_valid && !in_stall_q;
		cmd.clr_wr   = (state_q == ST_CLEAR);
		cmd.sum_step = (state_q == ST_EXEC) && sts.walk && !sts.sum_last;
		cmd.fire     = (state_q == ST_EXEC) && sts.out_free && (!sts.walk || sts.sum_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			in_stall_q <= 1'b1;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last) begin
						state_q    <= ST_IDLE;
						in_stall_q <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (cmd.latch) begin
						state_q    <= ST_EXEC;
						in_stall_q <= 1'b1;
					end
				end
				ST_EXEC: begin
					if (cmd.fire) begin
						state_q    <= ST_IDLE;
						in_stall_q <= 1'b0;
					end
				end
				default: begin
					state_q    <= ST_CLEAR;
					in_stall_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

@@ sv/tofh_dp.sv @@
module tofh_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tofh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tofh_pkg::CFG_DATA_W-1:0] cfg_data,
	input  tofh_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output tofh_pkg::out_item_t             out_data,
	input  tofh_pkg::cmd_t                  cmd,
	output tofh_pkg::sts_t                  sts
);
	import tofh_pkg::*;

	// configuration
	logic               use_weight_q;
	logic [SHIFT_W-1:0] resol_shift_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_weight_q  <= 1'b0;
			resol_shift_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_USE_WEIGHT:  use_weight_q  <= cfg_data[0];
				REG_RESOL_SHIFT: resol_shift_q <= cfg_data[SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	// decode of the incoming request
	logic [SHIFT_W-1:0] sh;
	logic [CH_W-1:0]    bin_in;
	logic [CH_W-1:0]    last_in;
	logic [CMP_W-1:0]   nb;
	logic               step_ok, bin_ok, last_ok, empty;
	logic               acc_ok_in, err_in, walk_in, need_read;
	logic [ADDR_W-1:0]  addr_in;

	always_comb begin
		sh      = (resol_shift_q > SHIFT_W'(MAX_SHIFT)) ? SHIFT_W'(MAX_SHIFT) : resol_shift_q;
		bin_in  = in_data.tof_channel >> sh;
		last_in = in_data.stop_channel >> sh;
		nb      = CMP_W'(TOF_CHANNELS) >> sh;
		step_ok = STEPC_W'(in_data.step_index) < STEPC_W'(NUM_STEPS);
		bin_ok  = CMP_W'(bin_in) < nb;
		last_ok = CMP_W'(last_in) < nb;
		empty   = bin_in > last_in;
		addr_in = ADDR_W'(in_data.step_index) * ADDR_W'(TOF_CHANNELS) + ADDR_W'(bin_in);
		acc_ok_in = 1'b0;
		err_in    = 1'b0;
		walk_in   = 1'b0;
		case (in_data.opcode)
			OP_ACCUM: acc_ok_in = in_data.filter_pass && step_ok && bin_ok;
			OP_READ:  err_in = !(step_ok && bin_ok);
			OP_SUM: begin
				err_in  = !empty && !(step_ok && last_ok);
				walk_in = !empty && step_ok && last_ok;
			end
			default: ;
		endcase
		need_read = acc_ok_in || walk_in || (in_data.opcode == OP_READ && !err_in);
	end

	// item registers
	logic [OP_W-1:0]     op_q;
	logic                acc_ok_q, err_q, walk_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [CH_W-1:0]     k_q;
	logic [CH_W-1:0]     last_q;
	logic [WEIGHT_W-1:0] add_q;
	logic [VALUE_W-1:0]  sum_q;

	// memory
	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [BIN_W-1:0]  ram_wdata, rdata;
	logic [ADDR_W-1:0] clr_q;

	// saturating adders
	logic [BIN_W:0]     bin_add;
	logic [BIN_W-1:0]   bin_new;
	logic [VALUE_W:0]   sum_add;
	logic [VALUE_W-1:0] sum_new;
	logic [COUNT_W-1:0] events_q, events_next;
	logic               acc_wr;

	always_comb begin
		bin_add = {1'b0, rdata} + (BIN_W+1)'(add_q);
		bin_new = bin_add[BIN_W] ? '1 : bin_add[BIN_W-1:0];
		sum_add = {1'b0, sum_q} + (VALUE_W+1)'(rdata);
		sum_new = sum_add[VALUE_W] ? '1 : sum_add[VALUE_W-1:0];
		acc_wr  = cmd.fire && (op_q == OP_ACCUM) && acc_ok_q;
		events_next = (acc_wr && events_q != '1) ? events_q + COUNT_W'(1) : events_q;
	end

	always_comb begin
		ram_re    = (cmd.latch && need_read) || cmd.sum_step;
		ram_raddr = cmd.latch ? addr_in : addr_q + ADDR_W'(1);
		ram_we    = cmd.clr_wr || acc_wr;
		ram_waddr = cmd.clr_wr ? clr_q : addr_q;
		ram_wdata = cmd.clr_wr ? '0 : bin_new;
	end

	tofh_ram #(
		.WIDTH (BIN_W),
		.DEPTH (DEPTH)
	) u_bins (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q     <= in_data.opcode;
			acc_ok_q <= acc_ok_in;
			err_q    <= err_in;
			walk_q   <= walk_in;
			addr_q   <= addr_in;
			k_q      <= bin_in;
			last_q   <= last_in;
			add_q    <= use_weight_q ? in_data.weight : WEIGHT_W'(ONE_COUNT);
			sum_q    <= '0;
		end else if (cmd.sum_step) begin
			addr_q <= addr_q + ADDR_W'(1);
			k_q    <= k_q + CH_W'(1);
			sum_q  <= sum_new;
		end
	end

	// clearing sweep and event counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			events_q <= '0;
		end else begin
			if (cmd.clr_wr) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			events_q <= events_next;
		end
	end

	// output register
	logic      out_valid_q;
	out_item_t res;

	always_comb begin
		res            = '0;
		res.used_count = events_next;
		case (op_q)
			OP_ACCUM: res.accepted = acc_ok_q;
			OP_READ: begin
				res.error = err_q;
				res.value = err_q ? '0 : VALUE_W'(rdata);
			end
			OP_SUM: begin
				res.error = err_q;
				res.value = walk_q ? sum_new : '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= cmd.fire || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fire) begin
			out_data <= res;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		sts          = '0;
		sts.clr_last = clr_q == ADDR_W'(DEPTH - 1);
		sts.walk     = walk_q;
		sts.sum_last = k_q == last_q;
		sts.out_free = !out_valid_q || !out_stall;
	end

endmodule

@@ sv/tof_histogram_accumulator_top.sv @@
// channel   direction  handshake            payload
// in        input      in_valid / in_stall  in_data   (in_item_t)
// out       output     out_valid/ out_stall out_data  (out_item_t)
// cfg       input      cfg_we               cfg_index, cfg_data
//
// accumulate and read requests first issue the bin read on the
// single registered-read memory port, then write back and register the result
// slice sums walk from start bin to stop bin, one bin read per cycle
// after reset a sweep over all DEPTH (65536) bins zeroes them; in_stall stays high
// until the sweep ends; a result waits in the output register under out_stall; the next request is
// taken once that register can accept the pending result
module tof_histogram_accumulator_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  tofh_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output tofh_pkg::out_item_t             out_data,
	input  logic                            cfg_we,
	input  logic [tofh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tofh_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tofh_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tofh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	tofh_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

@@ verif/tof_histogram_accumulator_top_tb.sv @@
`timescale 1ns / 1ps

module tof_histogram_accumulator_top_tb;
	import tofh_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam logic [63:0]     VALUE_MAX = (64'd1 << VALUE_W) - 64'd1;
	localparam int              HOLD_CYCLES = 400;
	localparam int              SETTLE_CYCLES = 4;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_item_t              in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_data;
	logic                  cfg_we = 1'b0;
	cfg_reg_t              cfg_index = REG_USE_WEIGHT;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predicted histogram contents and settings
	bit [BIN_W-1:0]   bin_store [0:DEPTH-1];
	bit [COUNT_W-1:0] events_seen;
	bit               use_weight_q;
	bit [SHIFT_W-1:0] resol_shift_q;

	out_item_t pending_results[$];
	int        mismatch_count = 0;
	bit        tx_idle_on = 1'b1;
	bit        rx_idle_on = 1'b1;
	int        holds_asked = 0;
	int        holds_served = 0;
	int        hold_left = 0;

	tof_histogram_accumulator_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic out_item_t histogram_predict(input in_item_t req);
		out_item_t   res;
		int unsigned sh;
		int unsigned nb;
		int unsigned first_bin;
		int unsigned last_bin;
		int unsigned base;
		int unsigned k;
		bit          step_ok;
		logic [32:0] grown;
		logic [31:0] add;
		logic [63:0] slice;
		res = '0;
		sh = (resol_shift_q > MAX_SHIFT) ? MAX_SHIFT : resol_shift_q;
		nb = TOF_CHANNELS >> sh;
		first_bin = req.tof_channel >> sh;
		last_bin = req.stop_channel >> sh;
		base = req.step_index * TOF_CHANNELS;
		step_ok = req.step_index < NUM_STEPS;
		case (req.opcode)
			OP_ACCUM: begin
				if (req.filter_pass && step_ok && first_bin < nb) begin
					add = use_weight_q ? 32'(req.weight) : 32'(ONE_COUNT);
					grown = {1'b0, bin_store[base + first_bin]} + {1'b0, add};
					bin_store[base + first_bin] = grown[32] ? '1 : grown[31:0];
					if (events_seen != '1)
						events_seen++;
					res.accepted = 1'b1;
				end
			end
			OP_READ: begin
				if (step_ok && first_bin < nb)
					res.value = VALUE_W'(bin_store[base + first_bin]);
				else
					res.error = 1'b1;
			end
			OP_SUM: begin
				if (first_bin <= last_bin) begin
					if (!step_ok || last_bin >= nb) begin
						res.error = 1'b1;
					end else begin
						slice = '0;
						for (k = first_bin; k <= last_bin; k++) begin
							slice += bin_store[base + k];
							if (slice > VALUE_MAX)
								slice = VALUE_MAX;
						end
						res.value = slice[VALUE_W-1:0];
					end
				end
			end
			default: ;
		endcase
		res.used_count = events_seen;
		return res;
	endfunction

	function automatic in_item_t make_req(input logic [OP_W-1:0] op, input int step,
			input int ch, input int stop, input logic [WEIGHT_W-1:0] w, input bit pass);
		in_item_t req;
		req.opcode = op;
		req.step_index = STEP_W'(step);
		req.tof_channel = CH_W'(ch);
		req.stop_channel = CH_W'(stop);
		req.weight = w;
		req.filter_pass = pass;
		return req;
	endfunction

	// mostly well-formed traffic around a few hot rows and channels so reads hit filled bins
	function automatic in_item_t random_request();
		in_item_t req;
		int       pick;
		int       span;
		pick = $urandom_range(99);
		if (pick < 58)
			req.opcode = OP_ACCUM;
		else if (pick < 78)
			req.opcode = OP_READ;
		else if (pick < 94)
			req.opcode = OP_SUM;
		else
			req.opcode = OP_UNUSED;
		if ($urandom_range(2) == 0)
			req.step_index = STEP_W'($urandom_range(63));
		else
			req.step_index = STEP_W'($urandom_range(3) + ($urandom_range(1) ? 60 : 0));
		if ($urandom_range(2) == 0)
			req.tof_channel = CH_W'($urandom_range(1023));
		else
			req.tof_channel = CH_W'($urandom_range(47) + ($urandom_range(1) ? 976 : 0));
		pick = $urandom_range(39);
		span = $urandom_range(48);
		if (pick == 0) begin
			req.tof_channel = '0;
			req.stop_channel = '1;
		end else if (pick < 4) begin
			req.stop_channel = CH_W'($urandom_range(1023));
		end else begin
			req.stop_channel = (req.tof_channel + span > 1023) ? CH_W'(1023)
				: CH_W'(req.tof_channel + span);
		end
		case ($urandom_range(3))
			0: req.weight = '0;
			1: req.weight = '1;
			default: req.weight = WEIGHT_W'($urandom);
		endcase
		req.filter_pass = $urandom_range(99) < 85;
		return req;
	endfunction

	task automatic send_request(input in_item_t req);
		int gap;
		gap = 0;
		if (tx_idle_on)
			while (gap < 8 && $urandom_range(99) < 33)
				gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.insert(pending_results.size(), histogram_predict(req));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// both registers, written back to back while nothing is in flight
	task automatic configure(input bit use_weight, input logic [SHIFT_W-1:0] shift);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= REG_USE_WEIGHT;
		cfg_data <= CFG_DATA_W'(use_weight);
		@(posedge clk);
		use_weight_q = use_weight;
		cfg_index <= REG_RESOL_SHIFT;
		cfg_data <= shift;
		@(posedge clk);
		resol_shift_q = shift;
		cfg_we <= 1'b0;
	endtask

	task automatic test_directed();
		configure(1'b0, 3'd0);
		send_request(make_req(OP_ACCUM, 0, 0, 0, 16'h0000, 1'b1));
		send_request(make_req(OP_ACCUM, 63, 1023, 1023, 16'hffff, 1'b1));
		send_request(make_req(OP_ACCUM, 63, 1023, 0, 16'hffff, 1'b0));
		send_request(make_req(OP_ACCUM, 0, 1, 0, 16'h1234, 1'b1));
		send_request(make_req(OP_READ, 0, 0, 0, 16'h0000, 1'b0));
		send_request(make_req(OP_READ, 63, 1023, 1023, 16'hffff, 1'b1));
		send_request(make_req(OP_SUM, 0, 0, 1023, 16'h0000, 1'b0));
		send_request(make_req(OP_SUM, 0, 10, 5, 16'h0000, 1'b0));
		send_request(make_req(OP_SUM, 0, 0, 1, 16'hffff, 1'b1));
		send_request(make_req(OP_UNUSED, 63, 1023, 1023, 16'hffff, 1'b1));
		// shift of 7 behaves as 4
		configure(1'b1, 3'd7);
		send_request(make_req(OP_ACCUM, 5, 1023, 0, 16'hffff, 1'b1));
		send_request(make_req(OP_ACCUM, 5, 1008, 0, 16'h0000, 1'b1));
		send_request(make_req(OP_ACCUM, 5, 0, 0, 16'h0100, 1'b1));
		send_request(make_req(OP_READ, 5, 1008, 0, 16'h0000, 1'b0));
		send_request(make_req(OP_READ, 0, 15, 0, 16'h0000, 1'b0));
		send_request(make_req(OP_SUM, 5, 0, 1023, 16'h0000, 1'b0));
		send_request(make_req(OP_SUM, 5, 1023, 0, 16'h0000, 1'b0));
		configure(1'b0, 3'd4);
		send_request(make_req(OP_ACCUM, 5, 16, 0, 16'h8000, 1'b1));
		send_request(make_req(OP_READ, 5, 31, 0, 16'h0000, 1'b0));
		send_request(make_req(OP_SUM, 5, 16, 1023, 16'h0000, 1'b0));
	endtask

	// max-weight events piled into one bin back to back, then read and summed
	task automatic test_bin_pileup();
		configure(1'b1, 3'd0);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		repeat (40) send_request(make_req(OP_ACCUM, 63, 1023, 0, 16'hffff, 1'b1));
		send_request(make_req(OP_READ, 63, 1023, 0, 16'h0000, 1'b0));
		send_request(make_req(OP_SUM, 63, 1020, 1023, 16'h0000, 1'b0));
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	task automatic test_backpressure();
		configure(1'b1, 3'd2);
		holds_asked++;
		tx_idle_on = 1'b0;
		repeat (40) send_request(random_request());
		tx_idle_on = 1'b1;
		// sender waits for every result before going on
		drain();
		repeat (20) send_request(random_request());
	endtask

	task automatic test_random();
		int phase;
		for (phase = 0; phase < 8; phase++) begin
			case (phase)
				0: configure(1'b0, 3'd0);
				1: configure(1'b1, 3'd4);
				2: configure(1'b1, 3'd0);
				default: configure(1'($urandom_range(1)), SHIFT_W'($urandom_range(7)));
			endcase
			tx_idle_on = phase != 3;
			rx_idle_on = phase != 3;
			repeat (85) send_request(random_request());
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// result side: random stalls plus a long hold-off whenever a test asks for one
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (holds_served != holds_asked) begin
			holds_served <= holds_asked;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= rx_idle_on && ($urandom_range(99) < 33);
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %p", $time, out_data);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (out_data.accepted !== want.accepted) begin
					$display("%0t: accepted expected %0d got %0d", $time, want.accepted,
						out_data.accepted);
					mismatch_count++;
				end
				if (out_data.value !== want.value) begin
					$display("%0t: value expected 0x%0h got 0x%0h", $time, want.value,
						out_data.value);
					mismatch_count++;
				end
				if (out_data.error !== want.error) begin
					$display("%0t: error expected %0d got %0d", $time, want.error,
						out_data.error);
					mismatch_count++;
				end
				if (out_data.used_count !== want.used_count) begin
					$display("%0t: used_count expected %0d got %0d", $time, want.used_count,
						out_data.used_count);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_bin_pileup();
		test_backpressure();
		test_random();
		drain();
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// generous bound: clearing sweep plus all the traffic many times over
	initial begin
		#15000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/tofh_pkg.sv
sv/tofh_ram.sv
sv/tofh_ctrl.sv
sv/tofh_dp.sv
sv/tof_histogram_accumulator_top.sv
verif/tof_histogram_accumulator_top_tb.sv
